/* design/framebuffer_pixel_fetch_convert_top_macros.svh */
// assertion macros for the framebuffer pixel fetch block
// used by framebuffer_pixel_fetch_convert_top, no other dependencies
`ifndef FRAMEBUFFER_PIXEL_FETCH_CONVERT_TOP_MACROS_SVH
`define FRAMEBUFFER_PIXEL_FETCH_CONVERT_TOP_MACROS_SVH

// same-cycle implication
`define FPFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fpfc_pkg.sv */
// shared widths, codes and constants of the framebuffer pixel fetch block
// no dependencies
`default_nettype none

package fpfc_pkg;

    localparam int unsigned MEM_WORDS_DEF = 1048576;

    localparam int WIDX_W  = 20;
    localparam int WDATA_W = 64;
    localparam int SX_W    = 10;
    localparam int SY_W    = 9;
    localparam int CH_W    = 8;
    localparam int DX_W    = 10;
    localparam int START_W = 23;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONCAT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 8'd3;

    localparam logic [1:0] DEPTH_0555 = 2'd0;
    localparam logic [1:0] DEPTH_565  = 2'd1;
    localparam logic [1:0] DEPTH_888  = 2'd2;
    localparam logic [1:0] DEPTH_0888 = 2'd3;

    localparam logic [11:0] STRIDE_16 = 12'd1280;
    localparam logic [11:0] STRIDE_24 = 12'd1920;
    localparam logic [11:0] STRIDE_32 = 12'd2560;

endpackage

`default_nettype wire

/* design/fpfc_in_if.sv */
// input channel of the pixel fetch block: memory writes and pixel fetches
// depends on fpfc_pkg
`default_nettype none

interface fpfc_in_if;
    import fpfc_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [WIDX_W-1:0]  word_index;
    logic [WDATA_W-1:0] write_data;
    logic [SX_W-1:0]    src_x;
    logic [SY_W-1:0]    src_y;

    modport source (output valid, op, word_index, write_data, src_x, src_y, input ready);
    modport sink   (input valid, op, word_index, write_data, src_x, src_y, output ready);
endinterface

`default_nettype wire

/* design/fpfc_out_if.sv */
// output channel of the pixel fetch block: converted rgb pixels
// depends on fpfc_pkg
`default_nettype none

interface fpfc_out_if;
    import fpfc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [DX_W-1:0] dest_x;
    logic            last;

    modport source (output valid, red, green, blue, dest_x, last, input ready);
    modport sink   (input valid, red, green, blue, dest_x, last, output ready);
endinterface

`default_nettype wire

/* design/fpfc_ram.sv */
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module fpfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

`default_nettype wire

/* design/framebuffer_pixel_fetch_convert_top.sv */
// top level of the framebuffer pixel fetch and format convert block
// depends on fpfc_pkg, fpfc_in_if, fpfc_out_if, fpfc_ram and the macros header
//
// i_pix carries one beat per item: op 0 writes write_data to memory word
// word_index, op 1 fetches the pixel at src_x/src_y and converts it to rgb.
// o_pix carries the converted pixels, one beat, or two with pixel doubling,
// the final one flagged by last. the cfg port writes start_address,
// pixel_depth, concat_bits and pixel_double by index, always ready. it is
// to be used only while no item is in flight; the block does not enforce it.
// one item is worked at a time. a pixel goes through an address stage, a
// word-number reduction, two reads of the single memory port and a format
// stage; i_pix is ready again in the cycle after the last beat is loaded.
// a write item goes through the word-number reduction and a write stage.
// a stalled receiver holds the output register; the second beat of a
// doubled pixel waits for the first to leave, and i_pix stays low meanwhile.
// reset clears the control state and the cfg registers, not the datapath
// registers; memory is not cleared.
`default_nettype none

`include "framebuffer_pixel_fetch_convert_top_macros.svh"

module framebuffer_pixel_fetch_convert_top #(
    parameter int unsigned MEM_WORDS = fpfc_pkg::MEM_WORDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fpfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fpfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fpfc_in_if.sink                              i_pix,
    fpfc_out_if.source                           o_pix
);
    import fpfc_pkg::*;

    localparam int AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int V_W   = 23;
    localparam int X_W   = V_W - 2;
    localparam int RED_W = ($clog2(MEM_WORDS + 1) > X_W) ? $clog2(MEM_WORDS + 1) : X_W;
    localparam int FL    = $clog2(MEM_WORDS + 1) - 1;
    localparam int KTOP  = (FL >= X_W - 1) ? 0 : (X_W - 1 - FL);
    localparam int STEP_W = (KTOP > 0) ? $clog2(KTOP + 1) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADDR = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_WR   = 8'b0000_1000,
        S_RD0  = 8'b0001_0000,
        S_RD1  = 8'b0010_0000,
        S_CAT  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [START_W-1:0] r_cfg_start;
    logic [1:0]         r_cfg_depth;
    logic [2:0]         r_cfg_concat;
    logic               r_cfg_double;

    logic               r_op;
    logic [SX_W-1:0]    r_sx;
    logic [SY_W-1:0]    r_sy;
    logic [WDATA_W-1:0] r_wdata;
    logic [RED_W-1:0]   r_rem;
    logic [RED_W-1:0]   r_div;
    logic [STEP_W-1:0]  r_step;
    logic [1:0]         r_off;
    logic [31:0]        r_lo;
    logic [CH_W-1:0]    r_pr, r_pg, r_pb;
    logic               r_copy, n_copy;
    logic               r_ov, n_ov;
    logic [CH_W-1:0]    r_red, r_green, r_blue;
    logic [DX_W-1:0]    r_dest_x;
    logic               r_last;

    logic               in_acc;
    logic               out_load;
    logic               ld_last;
    logic [11:0]        stride_full, stride;
    logic [11:0]        sx_bytes;
    logic [20:0]        sy_off;
    logic [V_W-1:0]     v_sum;
    logic [AW-1:0]      w0, w1;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [WDATA_W-1:0] ram_rdata;
    logic [31:0]        rd_half;
    logic [63:0]        cat;
    logic [31:0]        p32;
    logic [CH_W-1:0]    cv_r, cv_g, cv_b;

    assign o_cfg_ready = 1'b1;
    assign i_pix.ready = (r_state == S_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;

    // byte address of the pixel
    always_comb begin
        unique case (r_cfg_depth)
            DEPTH_888:  stride_full = STRIDE_24;
            DEPTH_0888: stride_full = STRIDE_32;
            default:    stride_full = STRIDE_16;
        endcase
        stride = r_cfg_double ? {1'b0, stride_full[11:1]} : stride_full;
        unique case (r_cfg_depth)
            DEPTH_888:  sx_bytes = {1'b0, r_sx, 1'b0} + {2'b00, r_sx};
            DEPTH_0888: sx_bytes = {r_sx, 2'b00};
            default:    sx_bytes = {1'b0, r_sx, 1'b0};
        endcase
        sy_off = r_sy * stride;
        v_sum  = {1'b0, r_cfg_start[21:2], 2'b00} + V_W'(sy_off) + V_W'(sx_bytes);
    end

    assign w0 = r_rem[AW-1:0];
    assign w1 = (w0 == AW'(MEM_WORDS - 1)) ? '0 : w0 + AW'(1);

    assign ram_we   = (r_state == S_WR);
    assign ram_addr = (r_state == S_RD1) ? w1 : w0;

    fpfc_ram #(
        .WIDTH (WDATA_W),
        .DEPTH (MEM_WORDS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_wdata),
        .o_rdata (ram_rdata)
    );

    // pixel bytes and format expansion
    always_comb begin
        rd_half = r_cfg_start[22] ? ram_rdata[63:32] : ram_rdata[31:0];
        cat     = {rd_half, r_lo};
        p32     = 32'(cat >> {r_off, 3'b000});
        unique case (r_cfg_depth)
            DEPTH_0555: begin
                cv_r = {p32[14:10], r_cfg_concat};
                cv_g = {p32[9:5], r_cfg_concat};
                cv_b = {p32[4:0], r_cfg_concat};
            end
            DEPTH_565: begin
                cv_r = {p32[15:11], r_cfg_concat};
                cv_g = {p32[10:5], r_cfg_concat[2:1]};
                cv_b = {p32[4:0], r_cfg_concat};
            end
            default: begin
                cv_r = p32[23:16];
                cv_g = p32[15:8];
                cv_b = p32[7:0];
            end
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_ov || o_pix.ready);
    assign ld_last  = !r_cfg_double || r_copy;

    always_comb begin
        n_state = r_state;
        n_copy  = r_copy;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_pix.op == OP_PIXEL) ? S_ADDR : S_MOD;
                end
            end
            S_ADDR: n_state = S_MOD;
            S_MOD: begin
                if (r_step == '0) begin
                    n_state = (r_op == OP_PIXEL) ? S_RD0 : S_WR;
                end
            end
            S_WR:  n_state = S_IDLE;
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_CAT;
            S_CAT: begin
                n_state = S_OUT;
                n_copy  = 1'b0;
            end
            S_OUT: begin
                if (out_load) begin
                    if (ld_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_copy = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (out_load) begin
            n_ov = 1'b1;
        end else if (o_pix.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_copy       <= 1'b0;
            r_ov         <= 1'b0;
            r_cfg_start  <= '0;
            r_cfg_depth  <= DEPTH_0555;
            r_cfg_concat <= '0;
            r_cfg_double <= 1'b0;
        end else begin
            r_state <= n_state;
            r_copy  <= n_copy;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START:  r_cfg_start  <= i_cfg_data[START_W-1:0];
                    CFG_DEPTH:  r_cfg_depth  <= i_cfg_data[1:0];
                    CFG_CONCAT: r_cfg_concat <= i_cfg_data[2:0];
                    CFG_DOUBLE: r_cfg_double <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_pix.op;
            r_sx    <= i_pix.src_x;
            r_sy    <= i_pix.src_y;
            r_wdata <= i_pix.write_data;
            if (i_pix.op == OP_WRITE) begin
                r_rem  <= RED_W'(i_pix.word_index);
                r_div  <= RED_W'(MEM_WORDS) << KTOP;
                r_step <= STEP_W'(KTOP);
            end
        end
        if (r_state == S_ADDR) begin
            r_rem  <= RED_W'(v_sum[V_W-1:2]);
            r_off  <= v_sum[1:0];
            r_div  <= RED_W'(MEM_WORDS) << KTOP;
            r_step <= STEP_W'(KTOP);
        end
        // word number modulo memory depth, one compare and subtract per cycle
        if (r_state == S_MOD) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
            end
            r_div  <= r_div >> 1;
            r_step <= r_step - STEP_W'(1);
        end
        if (r_state == S_RD1) begin
            r_lo <= rd_half;
        end
        if (r_state == S_CAT) begin
            r_pr <= cv_r;
            r_pg <= cv_g;
            r_pb <= cv_b;
        end
        if (out_load) begin
            r_red    <= r_pr;
            r_green  <= r_pg;
            r_blue   <= r_pb;
            r_dest_x <= r_cfg_double ? {r_sx[DX_W-2:0], r_copy} : r_sx;
            r_last   <= ld_last;
        end
    end

    assign o_pix.valid  = r_ov;
    assign o_pix.red    = r_red;
    assign o_pix.green  = r_green;
    assign o_pix.blue   = r_blue;
    assign o_pix.dest_x = r_dest_x;
    assign o_pix.last   = r_last;

    `FPFC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_acc, r_state != S_IDLE, "accepted item did not start")
    `FPFC_ASSERT_NEXT(a_word_in_range, i_clk, i_rst_n, (r_state == S_MOD) && (r_step == '0), r_rem < RED_W'(MEM_WORDS), "word number not reduced")
    `FPFC_ASSERT_IMP(a_first_copy_only_doubled, i_clk, i_rst_n, r_ov && !r_last, r_cfg_double, "non-final beat without doubling")

endmodule

`default_nettype wire
